@@ rtl/bsmr_pkg.sv @@
// Shared constants and types for the bounded stack with multi-pop and reserve.
package bsmr_pkg;

  localparam int STACK_DEPTH = 16;   // default number of stack cells
  localparam int MAX_RESULTS = 16;   // result beats one command may emit
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = 8;
  localparam int STATUS_W    = 2;
  localparam int FILL_W      = 5;

  // command kinds
  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESERVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NO_ROOM  = 2'd3;

  // how every cell moves in a cycle
  typedef enum logic [1:0] {
    SH_HOLD,
    SH_DOWN,   // take the word of the cell nearer the top
    SH_UP      // take the word of the cell farther from the top
  } shift_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

@@ rtl/bounded_stack_multi_pop_reserve.sv @@
// Top level: bounded LIFO stack built as a rotating chain of word cells.
// Usage: drive kind/value/count and raise start while busy is low; the
// command is taken at that clock edge. Push, failed commands and zero-count
// commands give one result beat; pop and reserve give one beat per entry
// moved (at most MAX_RESULTS), the final one flagged by last.
// Results appear on data/status/fill_level/last for exactly one cycle with
// strobe high, starting the cycle after the command is taken; the receiver
// cannot stall, so beats are never held. A multi-entry pop or reserve keeps
// busy high until its final beat is produced; single-beat commands leave
// busy low, and a new command may follow at once.
// The rate is set by the cell chain, which rotates one position per beat.
// Cell 0 always holds the word at the top of the stack; cell j holds the
// slot j below it, wrapping around, so the slots above the fill pointer sit
// at the far end of the chain. Push and reserve rotate toward the far end
// (push inserting the new word), pop rotates back toward cell 0.
// Reset (synchronous, active high) clears every cell to zero, empties the
// stack and drops busy and strobe.
module bounded_stack_multi_pop_reserve #(
  parameter int DEPTH = bsmr_pkg::STACK_DEPTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [bsmr_pkg::KIND_W-1:0]          kind,
  input  logic signed [bsmr_pkg::DATA_W-1:0]   value,
  input  logic [bsmr_pkg::COUNT_W-1:0]         count,
  output logic                                 strobe,
  output logic signed [bsmr_pkg::DATA_W-1:0]   data,
  output logic [bsmr_pkg::STATUS_W-1:0]        status,
  output logic [bsmr_pkg::FILL_W-1:0]          fill_level,
  output logic                                 last
);
  import bsmr_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);        // fill pointer width
  localparam int KW = $clog2(MAX_RESULTS + 1);  // beat counter width
  localparam int MW = CW + COUNT_W;             // compare width for clipping

  // chain of cells
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] head_in;
  shift_t                   mode;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic signed [DATA_W-1:0] prev_w;
    logic signed [DATA_W-1:0] next_w;
    if (j == 0) begin : g_first
      assign prev_w = head_in;
    end else begin : g_mid_prev
      assign prev_w = cell_q[j-1];
    end
    if (j == DEPTH - 1) begin : g_last
      assign next_w = cell_q[0];     // popped word wraps to the far end
    end else begin : g_mid_next
      assign next_w = cell_q[j+1];
    end
    bsmr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .mode      (mode),
      .from_prev (prev_w),
      .from_next (next_w),
      .q         (cell_q[j])
    );
  end

  // control state
  state_t        state, state_next;
  logic [CW-1:0] top, top_next;
  logic [KW-1:0] rem, rem_next;
  logic          run_pop, run_pop_next;

  // result beat, before the output register
  logic                       res_en;
  logic signed [DATA_W-1:0]   res_data;
  logic [STATUS_W-1:0]        res_status;
  logic                       res_last;
  logic [FILL_W-1:0]          res_fill;

  logic [KW-1:0] pop_k, rsv_k;

  // clipped entry counts for the command on the ports
  always_comb begin
    logic [MW-1:0] req;
    logic [MW-1:0] avail;
    logic [MW-1:0] room;
    logic [MW-1:0] m;
    req   = {{CW{1'b0}}, count};
    avail = {{COUNT_W{1'b0}}, top};
    room  = MW'(DEPTH) - avail;
    m     = (req < avail) ? req : avail;
    if (m > MW'(MAX_RESULTS)) m = MW'(MAX_RESULTS);
    pop_k = KW'(m);
    m     = (req < room) ? req : room;
    if (m > MW'(MAX_RESULTS)) m = MW'(MAX_RESULTS);
    rsv_k = KW'(m);
  end

  always_comb begin
    logic [CW+FILL_W-1:0] fill_ext;
    state_next   = state;
    top_next     = top;
    rem_next     = rem;
    run_pop_next = run_pop;
    mode         = SH_HOLD;
    head_in      = cell_q[DEPTH-1];
    res_en       = 1'b0;
    res_data     = '0;
    res_status   = STAT_OK;
    res_last     = 1'b1;

    case (state)
      ST_IDLE: begin
        if (start) begin
          res_en = 1'b1;
          case (kind)
            KIND_PUSH: begin
              if (top < CW'(DEPTH)) begin
                mode     = SH_DOWN;
                head_in  = value;
                top_next = top + CW'(1);
              end else begin
                res_status = STAT_FULL;
              end
            end
            KIND_POP: begin
              if (pop_k == '0) begin
                res_status = STAT_EMPTY;
              end else begin
                res_data     = cell_q[0];
                mode         = SH_UP;
                top_next     = top - CW'(1);
                res_last     = (pop_k == KW'(1));
                rem_next     = pop_k - KW'(1);
                run_pop_next = 1'b1;
                if (!res_last) state_next = ST_RUN;
              end
            end
            KIND_RESERVE: begin
              if (rsv_k == '0) begin
                res_status = STAT_NO_ROOM;
              end else begin
                res_data     = cell_q[DEPTH-1];
                mode         = SH_DOWN;
                top_next     = top + CW'(1);
                res_last     = (rsv_k == KW'(1));
                rem_next     = rsv_k - KW'(1);
                run_pop_next = 1'b0;
                if (!res_last) state_next = ST_RUN;
              end
            end
            default: ;   // unused kind: status-only beat, nothing moves
          endcase
        end
      end
      ST_RUN: begin
        res_en   = 1'b1;
        res_last = (rem == KW'(1));
        rem_next = rem - KW'(1);
        if (run_pop) begin
          res_data = cell_q[0];
          mode     = SH_UP;
          top_next = top - CW'(1);
        end else begin
          res_data = cell_q[DEPTH-1];
          mode     = SH_DOWN;
          top_next = top + CW'(1);
        end
        if (res_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase

    // fill_level reports the low bits of the pointer after the action
    fill_ext = {{FILL_W{1'b0}}, top_next};
    res_fill = fill_ext[FILL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      top     <= '0;
      rem     <= '0;
      run_pop <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      state   <= state_next;
      top     <= top_next;
      rem     <= rem_next;
      run_pop <= run_pop_next;
      strobe  <= res_en;
    end
  end

  // result payload, valid while strobe is high
  always_ff @(posedge clk) begin
    if (res_en) begin
      data       <= res_data;
      status     <= res_status;
      fill_level <= res_fill;
      last       <= res_last;
    end
  end

  assign busy = (state == ST_RUN);

endmodule

@@ rtl/bsmr_cell.sv @@
// One word cell of the rotating stack chain.
module bsmr_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  bsmr_pkg::shift_t                    mode,
  input  logic signed [bsmr_pkg::DATA_W-1:0]  from_prev,
  input  logic signed [bsmr_pkg::DATA_W-1:0]  from_next,
  output logic signed [bsmr_pkg::DATA_W-1:0]  q
);
  import bsmr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      case (mode)
        SH_DOWN: q <= from_prev;
        SH_UP:   q <= from_next;
        default: q <= q;
      endcase
    end
  end

endmodule
